// ===== rtl/hpc_pkg.sv =====
// ----------------------------------------------------------------------------
// hpc_pkg: shared types and constants of the haptic pattern controller
// Holds the operation and event codes, the mode codes, the configuration and
// result bundles, and the constants of the breathing and blink patterns.
// ----------------------------------------------------------------------------
package hpc_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned LevelW = 7;
  localparam int unsigned StepW  = 16;
  localparam int unsigned PhaseW = 6;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CfgIdxW = 2;

  // Operation codes carried by an input request.
  localparam logic [OpW-1:0] OP_TICK        = 3'd0;
  localparam logic [OpW-1:0] OP_BREATH_START = 3'd1;
  localparam logic [OpW-1:0] OP_BREATH_STOP  = 3'd2;
  localparam logic [OpW-1:0] OP_CALIB_START  = 3'd3;
  localparam logic [OpW-1:0] OP_DISCONNECT   = 3'd4;

  // Event codes reported with each result.
  localparam logic [OpW-1:0] EV_NONE          = 3'd0;
  localparam logic [OpW-1:0] EV_BREATH_START  = 3'd1;
  localparam logic [OpW-1:0] EV_BREATH_STOP   = 3'd2;
  localparam logic [OpW-1:0] EV_CALIB_START   = 3'd3;
  localparam logic [OpW-1:0] EV_CALIB_DONE    = 3'd4;
  localparam logic [OpW-1:0] EV_UNKNOWN       = 3'd5;

  // Operating modes.
  localparam logic [ModeW-1:0] MODE_IDLE   = 2'd0;
  localparam logic [ModeW-1:0] MODE_BREATH = 2'd1;
  localparam logic [ModeW-1:0] MODE_CALIB  = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_BREATH_STEP = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CALIB_MS    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CALIB_LEVEL = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_PRESENT     = 2'd3;

  // Configuration reset values.
  localparam logic [StepW-1:0]  BREATH_STEP_RST = 16'd120;
  localparam logic [TimeW-1:0]  CALIB_MS_RST    = 32'd12000;
  localparam logic [LevelW-1:0] CALIB_LEVEL_RST = 7'h35;

  // Triangle phase: 40 steps, rising for the first 20.
  localparam logic [PhaseW-1:0] PHASE_COUNT = 6'd40;
  localparam logic [PhaseW-1:0] PHASE_HALF  = 6'd20;
  localparam logic [PhaseW-1:0] PHASE_TOP   = 6'd39;

  // Blink half period is 250 ms. The parity of now/250 equals the parity of
  // (now>>1)/125, which is bit BLINK_SHIFT of (now>>1) * ceil(2^38/125).
  // The rounding error stays below one quotient step for any 31-bit value.
  localparam logic [TimeW-1:0] BLINK_RECIP = 32'd2199023256;
  localparam int unsigned      BLINK_SHIFT = 38;

  typedef struct packed {
    logic [StepW-1:0]  breath_step_ms;
    logic [TimeW-1:0]  calibration_ms;
    logic [LevelW-1:0] calibration_level;
    logic              haptic_present;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] motor_level;
    logic              led_on;
    logic [OpW-1:0]    event_code;
    logic              breath_active;
    logic              calibration_active;
  } res_t;

endpackage

// ===== rtl/hpc_blink.sv =====
// ----------------------------------------------------------------------------
// hpc_blink: calibration blink phase
// Tells whether the current 250 ms half period is an off half, using a
// constant reciprocal multiply instead of a divider.
// ----------------------------------------------------------------------------
module hpc_blink
  import hpc_pkg::*;
(
  input  logic [TimeW-1:0] now_ms_i,
  output logic             blink_off_o
);

  localparam int unsigned ProdW = 2 * TimeW - 1;

  logic [ProdW-1:0] prod;

  assign prod        = ProdW'(now_ms_i[TimeW-1:1]) * ProdW'(BLINK_RECIP);
  assign blink_off_o = prod[BLINK_SHIFT];

endmodule

// ===== rtl/hpc_seq.sv =====
// ----------------------------------------------------------------------------
// hpc_seq: pattern sequencer state and result register
// Applies one operation to the mode, phase and timing state and loads the
// result register in the same cycle.
// ----------------------------------------------------------------------------
module hpc_seq
  import hpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [OpW-1:0]   op_i,
  input  logic [TimeW-1:0] now_ms_i,
  input  cfg_t             cfg_i,
  input  logic             blink_off_i,
  output res_t             res_o
);

  logic [ModeW-1:0]  mode_q, mode_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [TimeW-1:0]  last_q, last_d;
  logic [TimeW-1:0]  start_q, start_d;
  logic [LevelW-1:0] drive_q, drive_d;
  logic [OpW-1:0]    event_d;
  res_t              res_q;

  logic [PhaseW-1:0] phase_cur;
  logic [PhaseW-1:0] phase_mirror;
  logic [LevelW-1:0] breath_level;
  logic [TimeW-1:0]  step_elapsed;
  logic [TimeW-1:0]  calib_elapsed;
  logic              step_due;
  logic              calib_done;

  assign phase_cur    = (phase_q >= PHASE_COUNT) ? '0 : phase_q;
  assign phase_mirror = PHASE_TOP - phase_cur;
  assign breath_level = (phase_cur < PHASE_HALF) ? {phase_cur[4:0], 2'b00}
                                                 : {phase_mirror[4:0], 2'b00};
  assign step_elapsed  = now_ms_i - last_q;
  assign calib_elapsed = now_ms_i - start_q;
  assign step_due      = step_elapsed >= {{(TimeW-StepW){1'b0}}, cfg_i.breath_step_ms};
  assign calib_done    = calib_elapsed >= cfg_i.calibration_ms;

  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    last_d  = last_q;
    start_d = start_q;
    drive_d = drive_q;
    event_d = EV_NONE;
    case (op_i)
      OP_TICK: begin
        if (mode_q == MODE_BREATH) begin
          if (step_due) begin
            last_d  = now_ms_i;
            drive_d = breath_level;
            phase_d = (phase_cur == PHASE_TOP) ? '0 : phase_cur + 6'd1;
          end
        end else if (mode_q == MODE_CALIB) begin
          drive_d = blink_off_i ? '0 : cfg_i.calibration_level;
          if (calib_done) begin
            mode_d  = MODE_IDLE;
            drive_d = '0;
            event_d = EV_CALIB_DONE;
          end
        end
      end
      OP_BREATH_START: begin
        mode_d  = MODE_BREATH;
        phase_d = '0;
        last_d  = '0;
        event_d = EV_BREATH_START;
      end
      OP_BREATH_STOP: begin
        mode_d  = MODE_IDLE;
        drive_d = '0;
        event_d = EV_BREATH_STOP;
      end
      OP_CALIB_START: begin
        mode_d  = MODE_CALIB;
        start_d = now_ms_i;
        event_d = EV_CALIB_START;
      end
      OP_DISCONNECT: begin
        mode_d  = MODE_IDLE;
        drive_d = '0;
      end
      default: begin
        event_d = EV_UNKNOWN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      phase_q <= '0;
      last_q  <= '0;
      start_q <= '0;
      drive_q <= '0;
    end else if (adv_i) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      last_q  <= last_d;
      start_q <= start_d;
      drive_q <= drive_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q.motor_level        <= cfg_i.haptic_present ? drive_d : '0;
      res_q.led_on             <= drive_d != '0;
      res_q.event_code         <= event_d;
      res_q.breath_active      <= mode_d == MODE_BREATH;
      res_q.calibration_active <= mode_d == MODE_CALIB;
    end
  end

  assign res_o = res_q;

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < PHASE_COUNT)
    else $error("breathing phase left its range");

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && (op_i == OP_BREATH_STOP || op_i == OP_DISCONNECT))
      |=> (drive_q == '0 && mode_q == MODE_IDLE))
    else $error("stop did not clear the drive level");

  a_calib_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && op_i == OP_CALIB_START)
      |=> (mode_q == MODE_CALIB && start_q == $past(now_ms_i)))
    else $error("calibration start not captured");
`endif

endmodule

// ===== rtl/haptic_pattern_controller_top.sv =====
// ----------------------------------------------------------------------------
// haptic_pattern_controller_top: haptic drive pattern sequencer
// Breathing and calibration blink patterns driven by timed requests, with a
// registered input stage, a sequencer stage and a result register.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ---------------------------------------
//  input     in_valid_i / in_ready_o   op_i, now_ms_i
//  result    out_valid_o / out_ready_i motor_level_o, led_on_o, event_code_o,
//                                      breath_active_o, calibration_active_o
//  config    cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// Every request passes through the input register and then the result
// register, and one request can be accepted in every cycle unless a result
// stalls; the sequencer state update plus the blink reciprocal multiply sit
// in the single stage between the input register and the result register.
// Reset brings the configuration to its defaults and the mode to idle with a
// drive level of zero; both pipeline registers come up empty.
// A stalled result holds the result register; the input register then holds
// its request and in_ready_o falls until the result is taken.
// ----------------------------------------------------------------------------
module haptic_pattern_controller_top
  import hpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OpW-1:0]     op_i,
  input  logic [TimeW-1:0]   now_ms_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [LevelW-1:0]  motor_level_o,
  output logic               led_on_o,
  output logic [OpW-1:0]     event_code_o,
  output logic               breath_active_o,
  output logic               calibration_active_o,

  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TimeW-1:0]   cfg_wdata_i
);

  // Configuration registers. Writes must arrive only while the block is idle,
  // which the block does not enforce; the sequencer reads them directly.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.breath_step_ms    <= BREATH_STEP_RST;
      cfg_q.calibration_ms    <= CALIB_MS_RST;
      cfg_q.calibration_level <= CALIB_LEVEL_RST;
      cfg_q.haptic_present    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BREATH_STEP: cfg_q.breath_step_ms    <= cfg_wdata_i[StepW-1:0];
        CFG_CALIB_MS:    cfg_q.calibration_ms    <= cfg_wdata_i;
        CFG_CALIB_LEVEL: cfg_q.calibration_level <= cfg_wdata_i[LevelW-1:0];
        CFG_PRESENT:     cfg_q.haptic_present    <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Input register. The request in it is processed in the cycle in which the
  // result register is free or being emptied.
  logic             in_vld_q;
  logic [OpW-1:0]   op_q;
  logic [TimeW-1:0] now_q;
  logic             out_vld_q;
  logic             adv;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q  <= op_i;
      now_q <= now_ms_i;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Blink half-period parity for the calibration pattern.
  logic blink_off;

  hpc_blink u_blink (
    .now_ms_i    (now_q),
    .blink_off_o (blink_off)
  );

  // Sequencer state and result register.
  res_t res;

  hpc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .op_i        (op_q),
    .now_ms_i    (now_q),
    .cfg_i       (cfg_q),
    .blink_off_i (blink_off),
    .res_o       (res)
  );

  assign out_valid_o          = out_vld_q;
  assign motor_level_o        = res.motor_level;
  assign led_on_o             = res.led_on;
  assign event_code_o         = res.event_code;
  assign breath_active_o      = res.breath_active;
  assign calibration_active_o = res.calibration_active;

`ifndef SYNTHESIS
  a_led_motor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res.led_on) |-> (res.motor_level == '0))
    else $error("motor driven while drive level is zero");

  a_modes_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(res.breath_active && res.calibration_active))
    else $error("breathing and calibration both active");

  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> (in_vld_q && $stable(op_q) && $stable(now_q)))
    else $error("stalled request lost from input register");
`endif

endmodule

// ===== sim/tb_haptic_pattern_controller_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_haptic_pattern_controller_top: self-checking bench of the haptic sequencer
// A scoreboard keeps its own copy of the mode, breathing phase, step and
// calibration times and the held level. It predicts one result per accepted
// request and compares each delivered result with the oldest prediction,
// field by field. Directed requests cover every operation and the corner
// cases. Random breathing runs, calibration runs and noise follow under
// several register settings, with idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module tb_haptic_pattern_controller_top
  import hpc_pkg::*;
;

  // Operation codes that the package leaves unnamed. All of them are unknown
  // commands to the sequencer.
  localparam logic [OpW-1:0]   OP_UNKNOWN  = 3'd5;
  localparam logic [OpW-1:0]   OP_SPARE_6  = 3'd6;
  localparam logic [OpW-1:0]   OP_SPARE_7  = 3'd7;
  localparam logic [TimeW-1:0] BLINK_HALF_MS = 32'd250;

  // Cycles without any handshake before the run is declared hung. The slowest
  // correct request waits out a send gap, a result stall and the input and
  // result registers, so this is far beyond any legal quiet stretch.
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 90;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the sequencer state and holds predicted results.
  // --------------------------------------------------------------------------
  class pattern_scoreboard;
    cfg_t              regs;
    logic [ModeW-1:0]  mode;
    logic [PhaseW-1:0] phase;
    logic [TimeW-1:0]  last_step_ms;
    logic [TimeW-1:0]  calib_start_ms;
    logic [LevelW-1:0] level;
    res_t              pending_drive_q[$];
    int unsigned       errors;

    function new();
      regs.breath_step_ms    = BREATH_STEP_RST;
      regs.calibration_ms    = CALIB_MS_RST;
      regs.calibration_level = CALIB_LEVEL_RST;
      regs.haptic_present    = 1'b1;
      mode           = MODE_IDLE;
      phase          = '0;
      last_step_ms   = '0;
      calib_start_ms = '0;
      level          = '0;
      errors         = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [TimeW-1:0] data);
      case (idx)
        CFG_BREATH_STEP: regs.breath_step_ms    = data[StepW-1:0];
        CFG_CALIB_MS:    regs.calibration_ms    = data;
        CFG_CALIB_LEVEL: regs.calibration_level = data[LevelW-1:0];
        CFG_PRESENT:     regs.haptic_present    = data[0];
        default: ;
      endcase
    endfunction

    // Advances the mirrored state by one request and queues the result.
    function void note_request(logic [OpW-1:0] op, logic [TimeW-1:0] now);
      logic [OpW-1:0]   ev;
      logic [TimeW-1:0] since;
      int unsigned      p;
      res_t             r;
      ev = EV_NONE;
      case (op)
        OP_TICK: begin
          if (mode == MODE_BREATH) begin
            since = now - last_step_ms;
            if (since >= regs.breath_step_ms) begin
              p = phase;
              if (p >= PHASE_COUNT) p = 0;
              last_step_ms = now;
              level = (p < PHASE_HALF) ? LevelW'(p * 4) : LevelW'((PHASE_TOP - p) * 4);
              phase = PhaseW'((p + 1) % PHASE_COUNT);
            end
          end else if (mode == MODE_CALIB) begin
            level = ((now / BLINK_HALF_MS) & 32'd1) == 32'd0 ? regs.calibration_level : '0;
            since = now - calib_start_ms;
            if (since >= regs.calibration_ms) begin
              mode  = MODE_IDLE;
              level = '0;
              ev    = EV_CALIB_DONE;
            end
          end
        end
        OP_BREATH_START: begin
          // The held level survives a restart; only the phase and step time are cleared.
          mode         = MODE_BREATH;
          phase        = '0;
          last_step_ms = '0;
          ev           = EV_BREATH_START;
        end
        OP_BREATH_STOP: begin
          mode  = MODE_IDLE;
          level = '0;
          ev    = EV_BREATH_STOP;
        end
        OP_CALIB_START: begin
          mode           = MODE_CALIB;
          calib_start_ms = now;
          ev             = EV_CALIB_START;
        end
        OP_DISCONNECT: begin
          mode  = MODE_IDLE;
          level = '0;
        end
        default: ev = EV_UNKNOWN;
      endcase
      r.motor_level        = regs.haptic_present ? level : '0;
      r.led_on             = level != '0;
      r.event_code         = ev;
      r.breath_active      = mode == MODE_BREATH;
      r.calibration_active = mode == MODE_CALIB;
      pending_drive_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_drive(res_t got);
      res_t want;
      if (pending_drive_q.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding, expected none, actual %h",
                 $time, got);
        return;
      end
      want = pending_drive_q.pop_front();
      compare_field("motor_level", want.motor_level, got.motor_level);
      compare_field("led_on", want.led_on, got.led_on);
      compare_field("event_code", want.event_code, got.event_code);
      compare_field("breath_active", want.breath_active, got.breath_active);
      compare_field("calibration_active", want.calibration_active, got.calibration_active);
    endfunction

    function int unsigned pending();
      return pending_drive_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block signals. Every input holds a known value from the
  // first instant of the run.
  // --------------------------------------------------------------------------
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [OpW-1:0]     op_i        = OP_TICK;
  logic [TimeW-1:0]   now_ms_i    = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b1;
  logic [LevelW-1:0]  motor_level_o;
  logic               led_on_o;
  logic [OpW-1:0]     event_code_o;
  logic               breath_active_o;
  logic               calibration_active_o;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = CFG_BREATH_STEP;
  logic [TimeW-1:0]   cfg_wdata_i = '0;

  res_t               observed;
  pattern_scoreboard  board;

  // Stimulus bookkeeping. The register copies only steer the random time
  // steps; prediction uses the scoreboard's own copy taken at the write.
  int unsigned        tx_idle_pct  = 0;
  int unsigned        rx_stall_pct = 0;
  int unsigned        requests_sent = 0;
  int unsigned        quiet_cycles  = 0;
  int unsigned        cur_step   = 120;
  logic [TimeW-1:0]   cur_cal_ms = 32'd12000;
  logic [TimeW-1:0]   clock_ms   = '0;

  assign observed = {motor_level_o, led_on_o, event_code_o, breath_active_o,
                     calibration_active_o};

  haptic_pattern_controller_top u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .op_i                 (op_i),
    .now_ms_i             (now_ms_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .motor_level_o        (motor_level_o),
    .led_on_o             (led_on_o),
    .event_code_o         (event_code_o),
    .breath_active_o      (breath_active_o),
    .calibration_active_o (calibration_active_o),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_wdata_i          (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Monitor. All handshakes are sampled at the rising edge, before any of the
  // nonblocking updates of that edge land, so the bench and the block agree
  // on which request, result and register write belong to each edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) board.write_reg(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && in_ready_o) board.note_request(op_i, now_ms_i);
      if (out_valid_o && out_ready_i) board.check_drive(observed);
    end
  end

  // Watchdog: a run that stops moving requests or results is a failure.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side back-pressure: random stall bursts while rx_stall_pct is
  // nonzero, steady ready otherwise.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offers one request and holds it until accepted. Any idle gap after it is
  // decided at the accepting edge, so valid is only lowered when a gap really
  // follows and a back-to-back request keeps valid high without a glitch.
  task automatic send(input logic [OpW-1:0] op, input logic [TimeW-1:0] t);
    int unsigned gap;
    in_valid_i <= 1'b1;
    op_i       <= op;
    now_ms_i   <= t;
    do @(posedge clk_i); while (!in_ready_o);
    requests_sent++;
    gap = 0;
    if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct)
      gap = $urandom_range(1, 12);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits until every predicted result has come back. The first edge makes
  // sure the monitor has already recorded the last accepted request; the
  // extra cycles cover the two-stage pipeline before registers change.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input int unsigned step, input logic [TimeW-1:0] cal_ms,
                              input logic [LevelW-1:0] lvl, input logic present);
    write_reg(CFG_BREATH_STEP, step);
    write_reg(CFG_CALIB_MS, cal_ms);
    write_reg(CFG_CALIB_LEVEL, {25'd0, lvl});
    write_reg(CFG_PRESENT, {31'd0, present});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cur_step   = step;
    cur_cal_ms = cal_ms;
  endtask

  // --------------------------------------------------------------------------
  // Random time steps
  // --------------------------------------------------------------------------

  // Starting time of a run: anywhere, just below the 32-bit wrap, or shortly
  // after the current time.
  function automatic logic [TimeW-1:0] fresh_time();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3000);
      default: return clock_ms + $urandom_range(0, 2000);
    endcase
  endfunction

  // Mostly a full step interval (so the phase moves), sometimes too short,
  // and now and then a wild jump that wraps the time difference.
  function automatic logic [TimeW-1:0] breath_delta();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return cur_step + $urandom_range(0, 3);
    if (pick < 9) return (cur_step == 0) ? 0 : $urandom_range(0, cur_step - 1);
    return $urandom();
  endfunction

  // --------------------------------------------------------------------------
  // Random traffic: breathing runs, calibration runs and noise bursts.
  // --------------------------------------------------------------------------
  task automatic run_traffic(input int unsigned count);
    int unsigned      stop_at;
    int unsigned      n;
    int unsigned      pick;
    logic [TimeW-1:0] start_ms;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        // Breathing run; long enough at times to walk the whole triangle.
        clock_ms = fresh_time();
        send(OP_BREATH_START, clock_ms);
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(45, 70) : $urandom_range(4, 30);
        repeat (n) begin
          clock_ms += breath_delta();
          if ($urandom_range(0, 24) == 0) send(OpW'(OP_TICK + $urandom_range(1, 7)), clock_ms);
          else send(OP_TICK, clock_ms);
        end
        case ($urandom_range(0, 3))
          0: send(OP_BREATH_STOP, clock_ms);
          1: send(OP_DISCONNECT, clock_ms);
          default: ;
        endcase
      end else if (pick < 8) begin
        // Calibration run; blink boundaries are close together in time and the
        // end of the duration is sometimes hit exactly or missed by one.
        clock_ms = fresh_time();
        start_ms = clock_ms;
        send(OP_CALIB_START, clock_ms);
        n = $urandom_range(3, 30);
        repeat (n) begin
          pick = $urandom_range(0, 9);
          if (pick < 6) clock_ms += $urandom_range(1, 300);
          else if (pick < 8) clock_ms += $urandom_range(0, 1000);
          else clock_ms = start_ms + cur_cal_ms - $urandom_range(0, 1);
          if ($urandom_range(0, 24) == 0) send(OpW'(OP_TICK + $urandom_range(1, 7)), clock_ms);
          else send(OP_TICK, clock_ms);
        end
        if ($urandom_range(0, 2) == 0) send(OP_BREATH_STOP, clock_ms);
      end else begin
        // Noise: any operation code at any time.
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) == 0) clock_ms = $urandom();
          else clock_ms += $urandom_range(0, 500);
          send(OpW'(OP_TICK + $urandom_range(0, 7)), clock_ms);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset register values: step 120 ms, calibration
    // of 12000 ms at level 53, driver present.
    tx_idle_pct  = 20;
    rx_stall_pct = 20;
    send(OP_TICK, 32'h0000_0000);          // tick while idle changes nothing
    send(OP_UNKNOWN, 32'hFFFF_FFFF);
    send(OP_SPARE_6, 32'h5555_5555);
    send(OP_SPARE_7, 32'hAAAA_AAAA);
    send(OP_BREATH_STOP, 32'd10);          // stop while idle still reports
    send(OP_DISCONNECT, 32'd20);
    send(OP_BREATH_START, 32'd100);
    send(OP_TICK, 32'd119);                // one short of a step from zero
    send(OP_TICK, 32'd120);                // first step, phase zero
    send(OP_TICK, 32'd240);
    send(OP_TICK, 32'd360);
    send(OP_UNKNOWN, 32'd370);             // unknown command keeps breathing
    send(OP_BREATH_START, 32'd400);        // restart keeps the held level
    send(OP_TICK, 32'd520);
    send(OP_CALIB_START, 32'd1000);        // calibration keeps the held level
    send(OP_TICK, 32'd1249);               // even half period, level on
    send(OP_TICK, 32'd1250);               // odd half period, level off
    send(OP_TICK, 32'd1500);
    send(OP_TICK, 32'd12999);              // one short of the duration
    send(OP_TICK, 32'd13000);              // duration reached, calibration done
    send(OP_TICK, 32'd13100);
    send(OP_CALIB_START, 32'hFFFF_FF00);
    send(OP_TICK, 32'h0000_0100);          // time difference across the wrap
    send(OP_BREATH_START, 32'd300);        // breathing takes over calibration
    send(OP_BREATH_STOP, 32'd310);
    send(OP_CALIB_START, 32'd5000);
    send(OP_DISCONNECT, 32'd5100);
    settle();

    // Random part: one register setting per phase, extremes first. The last
    // phases run without idling on either side.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_regs(1, 32'd1, 7'd127, 1'b1);
        1: program_regs(0, 32'd0, 7'd0, 1'b1);            // zero step, zero duration
        2: program_regs(65535, 32'hFFFF_FFFF, 7'd127, 1'b0);
        3: program_regs($urandom_range(1, 400), $urandom_range(300, 3000),
                        LevelW'($urandom_range(0, 127)), 1'b1);
        4: program_regs($urandom_range(1, 50), $urandom_range(500, 5000),
                        LevelW'($urandom_range(0, 127)), 1'b0);
        5: program_regs($urandom_range(0, 65535), $urandom(),
                        LevelW'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        6: program_regs($urandom_range(30, 200), $urandom_range(200, 2000),
                        LevelW'($urandom_range(1, 127)), 1'b1);
        default: program_regs(120, 32'd12000, 7'h35, 1'b1);
      endcase
      if (ph >= PHASES - 2) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end else begin
        tx_idle_pct  = (ph % 3 == 2) ? 0 : 15;
        rx_stall_pct = (ph % 3 == 1) ? 0 : 15;
      end
      run_traffic(PHASE_ITEMS);
      settle();
    end

    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hpc_pkg.sv
rtl/hpc_blink.sv
rtl/hpc_seq.sv
rtl/haptic_pattern_controller_top.sv
sim/tb_haptic_pattern_controller_top.sv
